// ===== src/lewh_pkg.sv =====
package lewh_pkg;

    localparam int LINE_CAP_DEF   = 64;
    localparam int HIST_DEPTH_DEF = 16;
    localparam int TAB_STOP_DEF   = 8;

    typedef struct packed {
        logic [7:0] key;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       eof_mark;
        logic       last;
    } out_item_t;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_BELL = 2'd1;
    localparam logic [1:0] KIND_INTR = 2'd2;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_CSI    = 3'd2;
    localparam logic [2:0] MODE_NUL    = 3'd3;
    localparam logic [2:0] MODE_QUOTE  = 3'd4;

    localparam logic [7:0] KEY_NUL      = 8'h00;
    localparam logic [7:0] KEY_CTRL_A   = 8'h01;
    localparam logic [7:0] KEY_CTRL_B   = 8'h02;
    localparam logic [7:0] KEY_CTRL_C   = 8'h03;
    localparam logic [7:0] KEY_EOT      = 8'h04;
    localparam logic [7:0] KEY_CTRL_E   = 8'h05;
    localparam logic [7:0] KEY_CTRL_F   = 8'h06;
    localparam logic [7:0] KEY_BS       = 8'h08;
    localparam logic [7:0] KEY_TAB      = 8'h09;
    localparam logic [7:0] KEY_LF       = 8'h0A;
    localparam logic [7:0] KEY_CTRL_K   = 8'h0B;
    localparam logic [7:0] KEY_CTRL_L   = 8'h0C;
    localparam logic [7:0] KEY_CR       = 8'h0D;
    localparam logic [7:0] KEY_CTRL_N   = 8'h0E;
    localparam logic [7:0] KEY_CTRL_P   = 8'h10;
    localparam logic [7:0] KEY_CTRL_U   = 8'h15;
    localparam logic [7:0] KEY_CTRL_V   = 8'h16;
    localparam logic [7:0] KEY_CTRL_X   = 8'h18;
    localparam logic [7:0] KEY_SUB      = 8'h1A;
    localparam logic [7:0] KEY_ESC      = 8'h1B;
    localparam logic [7:0] KEY_SPACE    = 8'h20;
    localparam logic [7:0] KEY_DEL      = 8'h7F;
    localparam logic [7:0] KEY_LBRACKET = 8'h5B;
    localparam logic [7:0] KEY_UP_A     = 8'h41;
    localparam logic [7:0] KEY_UP_B     = 8'h42;
    localparam logic [7:0] KEY_UP_C     = 8'h43;
    localparam logic [7:0] KEY_UP_D     = 8'h44;
    localparam logic [7:0] KEY_UP_G     = 8'h47;
    localparam logic [7:0] KEY_UP_H     = 8'h48;
    localparam logic [7:0] KEY_UP_K     = 8'h4B;
    localparam logic [7:0] KEY_UP_M     = 8'h4D;
    localparam logic [7:0] KEY_UP_O     = 8'h4F;
    localparam logic [7:0] KEY_UP_P     = 8'h50;
    localparam logic [7:0] KEY_UP_S     = 8'h53;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_BELL,
        OP_INTR,
        OP_MODE_ESC,
        OP_MODE_CSI,
        OP_MODE_NUL,
        OP_MODE_QUOTE,
        OP_START,
        OP_LEFT,
        OP_RIGHT,
        OP_END,
        OP_DEL_LEFT,
        OP_DEL_UNDER,
        OP_KILL,
        OP_ENTER,
        OP_HNEXT,
        OP_HPREV,
        OP_ERASE,
        OP_INSERT
    } op_t;

    function automatic op_t decode_key(logic [2:0] mode, logic [7:0] key);
        op_t op;
        op = OP_NONE;
        unique case (mode)
            MODE_ESC: begin
                op = (key == KEY_LBRACKET) ? OP_MODE_CSI : OP_BELL;
            end
            MODE_CSI: begin
                unique case (key)
                    KEY_UP_A: op = OP_HPREV;
                    KEY_UP_B: op = OP_HNEXT;
                    KEY_UP_C: op = OP_RIGHT;
                    KEY_UP_D: op = OP_LEFT;
                    default:  op = OP_BELL;
                endcase
            end
            MODE_NUL: begin
                unique case (key)
                    KEY_UP_H: op = OP_HPREV;
                    KEY_UP_P: op = OP_HNEXT;
                    KEY_UP_M: op = OP_RIGHT;
                    KEY_UP_K: op = OP_LEFT;
                    KEY_UP_S: op = OP_DEL_UNDER;
                    KEY_UP_G: op = OP_START;
                    KEY_UP_O: op = OP_END;
                    default:  op = OP_BELL;
                endcase
            end
            MODE_QUOTE: begin
                op = OP_INSERT;
            end
            default: begin
                unique case (key) inside
                    KEY_NUL:          op = OP_MODE_NUL;
                    KEY_CTRL_A:       op = OP_START;
                    KEY_CTRL_B:       op = OP_LEFT;
                    KEY_CTRL_C:       op = OP_INTR;
                    KEY_CTRL_E:       op = OP_END;
                    KEY_CTRL_F:       op = OP_RIGHT;
                    KEY_BS:           op = OP_DEL_LEFT;
                    KEY_LF, KEY_CR:   op = OP_ENTER;
                    KEY_CTRL_K:       op = OP_KILL;
                    KEY_CTRL_L:       op = OP_NONE;
                    KEY_CTRL_N:       op = OP_HNEXT;
                    KEY_CTRL_P:       op = OP_HPREV;
                    KEY_CTRL_U:       op = OP_ERASE;
                    KEY_CTRL_V:       op = OP_MODE_QUOTE;
                    KEY_CTRL_X, KEY_DEL: op = OP_DEL_UNDER;
                    KEY_ESC:          op = OP_MODE_ESC;
                    default:          op = OP_INSERT;
                endcase
            end
        endcase
        return op;
    endfunction

endpackage

// ===== src/lewh_store.sv =====
module lewh_store
    import lewh_pkg::*;
#(
    parameter int LINE_CAP   = LINE_CAP_DEF,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF,
    localparam int LA_W = $clog2(LINE_CAP),
    localparam int HA_W = $clog2(HIST_DEPTH * LINE_CAP)
) (
    input  logic            aclk,
    input  logic            line_re,
    input  logic [LA_W-1:0] line_raddr,
    output logic [7:0]      line_rdata,
    input  logic            line_we,
    input  logic [LA_W-1:0] line_waddr,
    input  logic [7:0]      line_wdata,
    input  logic            hist_re,
    input  logic [HA_W-1:0] hist_raddr,
    output logic [7:0]      hist_rdata,
    input  logic            hist_we,
    input  logic [HA_W-1:0] hist_waddr,
    input  logic [7:0]      hist_wdata
);

    logic [7:0] line_mem [LINE_CAP];
    logic [7:0] hist_mem [HIST_DEPTH * LINE_CAP];

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (line_we) begin
            line_mem[line_waddr] <= line_wdata;
        end
        if (line_re) begin
            line_rdata <= line_mem[line_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_re) begin
            hist_rdata <= hist_mem[hist_raddr];
        end
    end

endmodule

// ===== src/lewh_out_reg.sv =====
module lewh_out_reg
    import lewh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    input  out_item_t push_item,
    output logic      out_free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    logic      valid_reg;
    out_item_t item_reg;

    assign out_free  = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_payload = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid && out_free) begin
            item_reg <= push_item;
        end
    end

endmodule

// ===== src/line_editor_with_history_core.sv =====
// Line editor with history ring.
// Input channel s_*: one request per keystroke byte, or an end-of-input mark
// that acts as ^D followed by newline. Result channel m_*: bells, interrupt
// requests and, on enter, the line bytes followed by a newline; last flags
// the final result of each request.
// s_ready is high only while the sequencer is idle, one request at a time.
// Cursor moves and mode changes finish in dispatch; a bell or interrupt adds a push.
// Insert shifts the bytes from the cursor up, then writes the n inserted bytes;
// deletes shift the tail down; a history recall copies the entry into the line.
// Enter compares against the newest entry when lengths match, then streams
// one byte a cycle from the line memory while the output register is free.
// The line store and history text are single-port-read synchronous memories;
// every shift, copy and compare walks them one byte a cycle.
// Reset clears cursor, length, mode, ring pointers and history lengths; the
// memories need no clearing. A stalled receiver holds the output register;
// the sequencer waits in place until that register frees.
module line_editor_with_history_core
    import lewh_pkg::*;
#(
    parameter int LINE_CAP   = LINE_CAP_DEF,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF,
    parameter int TAB_STOP   = TAB_STOP_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    localparam int LA_W = $clog2(LINE_CAP);
    localparam int HS_W = $clog2(HIST_DEPTH);
    localparam int HA_W = $clog2(HIST_DEPTH * LINE_CAP);
    localparam int TK_W = $clog2(TAB_STOP + 1);
    localparam int CW   = LA_W + TK_W;
    localparam logic [LA_W-1:0] LEN_MAX   = LA_W'(LINE_CAP - 1);
    localparam logic [HS_W-1:0] SLOT_LAST = HS_W'(HIST_DEPTH - 1);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_DISPATCH  = 10'b0000000010,
        ST_INS_SHIFT = 10'b0000000100,
        ST_INS_FILL  = 10'b0000001000,
        ST_DEL_SHIFT = 10'b0000010000,
        ST_LOAD      = 10'b0000100000,
        ST_CMP       = 10'b0001000000,
        ST_EMIT_RD   = 10'b0010000000,
        ST_EMIT      = 10'b0100000000,
        ST_PUSH      = 10'b1000000000
    } state_t;

    function automatic logic [CW-1:0] tab_rem(logic [LA_W-1:0] v);
        logic [CW-1:0] r;
        logic [CW-1:0] d;
        r = CW'(v);
        for (int s = LA_W - 1; s >= 0; s--) begin
            d = CW'(TAB_STOP) << s;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r;
    endfunction

    function automatic logic [HS_W-1:0] slot_inc(logic [HS_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + HS_W'(1);
    endfunction

    function automatic logic [HS_W-1:0] slot_dec(logic [HS_W-1:0] s);
        return (s == '0) ? SLOT_LAST : s - HS_W'(1);
    endfunction

    function automatic logic [HA_W-1:0] slot_base(logic [HS_W-1:0] s);
        return HA_W'(HA_W'(s) * HA_W'(LINE_CAP));
    endfunction

    // control state
    state_t          state_reg, state_next;
    logic [2:0]      mode_reg, mode_next;
    logic [LA_W-1:0] cur_reg, cur_next;
    logic [LA_W-1:0] len_reg, len_next;
    logic [HS_W-1:0] head_reg, head_next;
    logic [HS_W-1:0] view_reg, view_next;
    logic [LA_W-1:0] hlen_reg [HIST_DEPTH];
    logic [LA_W-1:0] hlen_next [HIST_DEPTH];
    logic            eof_reg, eof_next;
    logic            mute_reg, mute_next;
    logic            pend_v_reg, pend_v_next;

    // working registers
    logic [7:0]      key_reg, key_next;
    logic [LA_W-1:0] idx_reg, idx_next;
    logic [LA_W-1:0] pend_idx_reg, pend_idx_next;
    logic [LA_W-1:0] nins_reg, nins_next;
    logic [7:0]      ins_char_reg, ins_char_next;
    logic            short_reg, short_next;
    logic            store_reg, store_next;
    logic [HA_W-1:0] hbase_reg, hbase_next;
    logic [1:0]      push_kind_reg, push_kind_next;
    logic [7:0]      push_data_reg, push_data_next;

    op_t             op;
    logic [HS_W-1:0] hl_idx;
    logic [LA_W-1:0] hl_len;
    logic [CW-1:0]   tab_k;
    logic [CW-1:0]   avail;
    logic [CW-1:0]   n_ins;

    logic            line_re, line_we, hist_re, hist_we;
    logic [LA_W-1:0] line_raddr, line_waddr;
    logic [HA_W-1:0] hist_raddr, hist_waddr;
    logic [7:0]      line_rdata, line_wdata, hist_rdata, hist_wdata;

    logic            push_valid;
    out_item_t       push_item;
    logic            out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign op      = decode_key(mode_reg, key_reg);

    // one length lookup per request, selected by the operation
    always_comb begin
        case (op)
            OP_HPREV: hl_idx = slot_dec(view_reg);
            OP_HNEXT: hl_idx = slot_inc(view_reg);
            default:  hl_idx = slot_dec(head_reg);
        endcase
    end
    assign hl_len = hlen_reg[hl_idx];

    assign tab_k = (key_reg == KEY_TAB) ? CW'(TAB_STOP) - tab_rem(cur_reg) : CW'(1);
    assign avail = CW'(LEN_MAX - len_reg);
    assign n_ins = (tab_k > avail) ? avail : tab_k;

    always_comb begin : next_logic
        logic fin;
        logic bell;
        logic enter_end;
        fin       = 1'b0;
        bell      = 1'b0;
        enter_end = 1'b0;

        state_next     = state_reg;
        mode_next      = mode_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;
        head_next      = head_reg;
        view_next      = view_reg;
        hlen_next      = hlen_reg;
        eof_next       = eof_reg;
        mute_next      = mute_reg;
        pend_v_next    = 1'b0;
        key_next       = key_reg;
        idx_next       = idx_reg;
        pend_idx_next  = pend_idx_reg;
        nins_next      = nins_reg;
        ins_char_next  = ins_char_reg;
        short_next     = short_reg;
        store_next     = store_reg;
        hbase_next     = hbase_reg;
        push_kind_next = push_kind_reg;
        push_data_next = push_data_reg;

        line_re    = 1'b0;
        line_raddr = '0;
        line_we    = 1'b0;
        line_waddr = '0;
        line_wdata = '0;
        hist_re    = 1'b0;
        hist_raddr = '0;
        hist_we    = 1'b0;
        hist_waddr = '0;
        hist_wdata = '0;
        push_valid = 1'b0;
        push_item  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_payload.end_of_input) begin
                        key_next  = KEY_EOT;
                        eof_next  = 1'b1;
                        mute_next = 1'b1;
                    end else begin
                        key_next = s_payload.key;
                    end
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                mode_next = MODE_NORMAL;
                case (op)
                    OP_NONE:       fin = 1'b1;
                    OP_BELL:       bell = 1'b1;
                    OP_MODE_ESC:   begin mode_next = MODE_ESC;   fin = 1'b1; end
                    OP_MODE_CSI:   begin mode_next = MODE_CSI;   fin = 1'b1; end
                    OP_MODE_NUL:   begin mode_next = MODE_NUL;   fin = 1'b1; end
                    OP_MODE_QUOTE: begin mode_next = MODE_QUOTE; fin = 1'b1; end
                    OP_INTR: begin
                        push_kind_next = KIND_INTR;
                        push_data_next = '0;
                        state_next     = ST_PUSH;
                    end
                    OP_START: begin
                        cur_next = '0;
                        fin      = 1'b1;
                    end
                    OP_END: begin
                        cur_next = len_reg;
                        fin      = 1'b1;
                    end
                    OP_LEFT: begin
                        if (cur_reg != '0) begin
                            cur_next = cur_reg - LA_W'(1);
                        end
                        fin = 1'b1;
                    end
                    OP_RIGHT: begin
                        if (cur_reg < len_reg) begin
                            cur_next = cur_reg + LA_W'(1);
                        end
                        fin = 1'b1;
                    end
                    OP_KILL: begin
                        if (cur_reg < len_reg) begin
                            len_next = cur_reg;
                        end
                        fin = 1'b1;
                    end
                    OP_ERASE: begin
                        cur_next  = '0;
                        len_next  = '0;
                        view_next = head_reg;
                        fin       = 1'b1;
                    end
                    OP_DEL_UNDER: begin
                        if (cur_reg < len_reg) begin
                            idx_next   = cur_reg + LA_W'(1);
                            state_next = ST_DEL_SHIFT;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    OP_DEL_LEFT: begin
                        if (cur_reg != '0) begin
                            idx_next   = cur_reg;
                            cur_next   = cur_reg - LA_W'(1);
                            state_next = ST_DEL_SHIFT;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (n_ins == '0) begin
                            bell = 1'b1;
                        end else begin
                            nins_next     = LA_W'(n_ins);
                            short_next    = (tab_k > avail);
                            ins_char_next = (key_reg == KEY_TAB) ? KEY_SPACE : key_reg;
                            idx_next      = len_reg;
                            state_next    = ST_INS_SHIFT;
                        end
                    end
                    OP_ENTER: begin
                        if (len_reg == '0) begin
                            store_next = 1'b0;
                            state_next = ST_EMIT_RD;
                        end else if (hl_len != len_reg) begin
                            store_next = 1'b1;
                            state_next = ST_EMIT_RD;
                        end else begin
                            store_next = 1'b0;
                            hbase_next = slot_base(hl_idx);
                            idx_next   = '0;
                            state_next = ST_CMP;
                        end
                    end
                    OP_HPREV, OP_HNEXT: begin
                        // an empty slot marks the oldest end; the newest end is the head
                        if ((op == OP_HPREV) ? (hl_len != '0) : (view_reg != head_reg)) begin
                            view_next  = hl_idx;
                            len_next   = hl_len;
                            cur_next   = hl_len;
                            hbase_next = slot_base(hl_idx);
                            idx_next   = '0;
                            state_next = ST_LOAD;
                        end else begin
                            bell = 1'b1;
                        end
                    end
                    default: fin = 1'b1;
                endcase
            end

            ST_INS_SHIFT: begin
                // walk down from the end, each byte moves up by the insert count
                if (idx_reg != cur_reg) begin
                    line_re       = 1'b1;
                    line_raddr    = idx_reg - LA_W'(1);
                    pend_v_next   = 1'b1;
                    pend_idx_next = idx_reg - LA_W'(1);
                    idx_next      = idx_reg - LA_W'(1);
                end
                if (pend_v_reg) begin
                    line_we    = 1'b1;
                    line_waddr = pend_idx_reg + nins_reg;
                    line_wdata = line_rdata;
                end
                if (idx_reg == cur_reg && !pend_v_reg) begin
                    idx_next   = cur_reg;
                    state_next = ST_INS_FILL;
                end
            end

            ST_INS_FILL: begin
                line_we    = 1'b1;
                line_waddr = idx_reg;
                line_wdata = ins_char_reg;
                idx_next   = idx_reg + LA_W'(1);
                if (idx_reg + LA_W'(1) == cur_reg + nins_reg) begin
                    len_next = len_reg + nins_reg;
                    cur_next = cur_reg + nins_reg;
                    if (short_reg) begin
                        bell = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end

            ST_DEL_SHIFT: begin
                if (idx_reg != len_reg) begin
                    line_re       = 1'b1;
                    line_raddr    = idx_reg;
                    pend_v_next   = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + LA_W'(1);
                end
                if (pend_v_reg) begin
                    line_we    = 1'b1;
                    line_waddr = pend_idx_reg - LA_W'(1);
                    line_wdata = line_rdata;
                end
                if (idx_reg == len_reg && !pend_v_reg) begin
                    len_next = len_reg - LA_W'(1);
                    fin      = 1'b1;
                end
            end

            ST_LOAD: begin
                if (idx_reg != len_reg) begin
                    hist_re       = 1'b1;
                    hist_raddr    = hbase_reg + HA_W'(idx_reg);
                    pend_v_next   = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_reg + LA_W'(1);
                end
                if (pend_v_reg) begin
                    line_we    = 1'b1;
                    line_waddr = pend_idx_reg;
                    line_wdata = hist_rdata;
                end
                if (idx_reg == len_reg && !pend_v_reg) begin
                    fin = 1'b1;
                end
            end

            ST_CMP: begin
                if (idx_reg != len_reg) begin
                    line_re     = 1'b1;
                    line_raddr  = idx_reg;
                    hist_re     = 1'b1;
                    hist_raddr  = hbase_reg + HA_W'(idx_reg);
                    pend_v_next = 1'b1;
                    idx_next    = idx_reg + LA_W'(1);
                end
                if (pend_v_reg && line_rdata != hist_rdata) begin
                    store_next = 1'b1;
                end
                if (idx_reg == len_reg && !pend_v_reg) begin
                    state_next = ST_EMIT_RD;
                end
            end

            ST_EMIT_RD: begin
                hbase_next = slot_base(head_reg);
                idx_next   = '0;
                if (len_reg == '0) begin
                    enter_end = 1'b1;
                end else begin
                    line_re    = 1'b1;
                    line_raddr = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                // the byte leaves and, for a new entry, is copied into the ring
                if (out_free) begin
                    push_valid = 1'b1;
                    push_item  = '{kind: KIND_BYTE, data: line_rdata,
                                   eof_mark: (line_rdata == KEY_SUB) || (line_rdata == KEY_EOT),
                                   last: 1'b0};
                    if (store_reg) begin
                        hist_we    = 1'b1;
                        hist_waddr = hbase_reg + HA_W'(idx_reg);
                        hist_wdata = line_rdata;
                    end
                    if (idx_reg + LA_W'(1) == len_reg) begin
                        enter_end = 1'b1;
                    end else begin
                        line_re    = 1'b1;
                        line_raddr = idx_reg + LA_W'(1);
                        idx_next   = idx_reg + LA_W'(1);
                    end
                end
            end

            ST_PUSH: begin
                if (out_free) begin
                    push_valid = 1'b1;
                    push_item  = '{kind: push_kind_reg, data: push_data_reg,
                                   eof_mark: 1'b0, last: 1'b1};
                    fin = 1'b1;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        if (enter_end) begin
            if (store_reg) begin
                hlen_next[head_reg]           = len_reg;
                hlen_next[slot_inc(head_reg)] = '0;
                head_next                     = slot_inc(head_reg);
                view_next                     = slot_inc(head_reg);
            end else begin
                view_next = head_reg;
            end
            len_next       = '0;
            cur_next       = '0;
            push_kind_next = KIND_BYTE;
            push_data_next = KEY_LF;
            state_next     = ST_PUSH;
        end

        if (bell) begin
            if (mute_reg) begin
                fin = 1'b1;
            end else begin
                push_kind_next = KIND_BELL;
                push_data_next = '0;
                state_next     = ST_PUSH;
            end
        end

        // end of input: the ^D part is done, now run a newline
        if (fin) begin
            if (eof_reg) begin
                eof_next   = 1'b0;
                mute_next  = 1'b0;
                key_next   = KEY_LF;
                state_next = ST_DISPATCH;
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_NORMAL;
            cur_reg    <= '0;
            len_reg    <= '0;
            head_reg   <= '0;
            view_reg   <= '0;
            eof_reg    <= 1'b0;
            mute_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hlen_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            cur_reg    <= cur_next;
            len_reg    <= len_next;
            head_reg   <= head_next;
            view_reg   <= view_next;
            eof_reg    <= eof_next;
            mute_reg   <= mute_next;
            pend_v_reg <= pend_v_next;
            hlen_reg   <= hlen_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        nins_reg      <= nins_next;
        ins_char_reg  <= ins_char_next;
        short_reg     <= short_next;
        store_reg     <= store_next;
        hbase_reg     <= hbase_next;
        push_kind_reg <= push_kind_next;
        push_data_reg <= push_data_next;
    end

    lewh_store #(
        .LINE_CAP  (LINE_CAP),
        .HIST_DEPTH(HIST_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .line_re   (line_re),
        .line_raddr(line_raddr),
        .line_rdata(line_rdata),
        .line_we   (line_we),
        .line_waddr(line_waddr),
        .line_wdata(line_wdata),
        .hist_re   (hist_re),
        .hist_raddr(hist_raddr),
        .hist_rdata(hist_rdata),
        .hist_we   (hist_we),
        .hist_waddr(hist_waddr),
        .hist_wdata(hist_wdata)
    );

    lewh_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_item (push_item),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= len_reg)
        else $error("cursor beyond line end");

    a_line_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("line length over capacity");

    a_head_slot_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        hlen_reg[head_reg] == '0)
        else $error("history head slot not empty");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!eof_reg && !mute_reg && !pend_v_reg))
        else $error("idle with work pending");

endmodule
